### hw/rtl/additive_radial_blob_splat_assert.svh
// Assertion macros used by the checker of the blob splatter.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef ADDITIVE_RADIAL_BLOB_SPLAT_ASSERT_SVH
`define ADDITIVE_RADIAL_BLOB_SPLAT_ASSERT_SVH

// Check a property in the same cycle (the property carries its own implication).
`define ARBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define ARBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

### hw/rtl/arbs_pkg.sv
// Shared types, constants and the distance table of the blob splatter.
// Used by the controller, the datapath, the top level and the checker.
package arbs_pkg;

    // Default sizes, overridable by top-level parameters
    localparam int unsigned DEF_MAX_RADIUS = 5;
    localparam int unsigned DEF_MAX_WIDTH  = 128;
    localparam int unsigned DEF_MAX_HEIGHT = 128;

    // Field and register widths
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned POS_W     = 10;
    localparam int unsigned LIFE_W    = 9;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned MIR_W     = 2;

    // Fraction bits of life and of distances (Q.8)
    localparam int unsigned FRAC_W = 8;
    // Offsets up to 7 cover the whole radius range of the table
    localparam int unsigned OFF_TAB_W = 3;
    // Distances and radii in Q.8 below 16.0 fit 12 bits
    localparam int unsigned DIST_W = 12;
    localparam int unsigned RAD_W  = 12;
    // Amount is 3*diff/(8*R), done as a multiply by a scaled reciprocal
    localparam int unsigned RECIP_SHIFT = 20;

    localparam logic [LIFE_W-1:0] LIFE_ONE    = LIFE_W'(256);
    localparam logic [PIX_W-1:0]  PIX_MAX     = 8'd255;
    localparam logic [CNT_W-1:0]  CNT_MAX     = 7'd127;
    localparam logic [CFG_W-1:0]  FRAME_W_RST = 8'd128;
    localparam logic [CFG_W-1:0]  FRAME_H_RST = 8'd128;
    localparam logic [MIR_W-1:0]  MIR_LAST    = 2'b11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Request codes; the fourth code is not a request and does nothing
    typedef enum logic [REQ_W-1:0] {
        REQ_SPLAT = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } req_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic load;
        logic slot_step;
        logic result_load;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic pipe_busy;
    } dp_status_t;

    // round(256*sqrt(a*a+b*b)) indexed by {a, b}
    typedef logic [(1 << (2 * OFF_TAB_W))-1:0][DIST_W-1:0] dist_tab_t;

    function automatic dist_tab_t build_dist_tab();
        dist_tab_t   tab;
        int unsigned v;
        int unsigned r;
        int unsigned t;
        tab = '0;
        for (int a = 0; a < (1 << OFF_TAB_W); a++) begin
            for (int b = 0; b < (1 << OFF_TAB_W); b++) begin
                v = unsigned'(a * a + b * b) * 32'd65536;
                r = 0;
                // Largest r with r*r <= v, one bit at a time
                for (int k = DIST_W - 1; k >= 0; k--) begin
                    t = r | (32'd1 << k);
                    if (t * t <= v) begin
                        r = t;
                    end
                end
                // Round to nearest
                if (v - r * r > r) begin
                    r = r + 1;
                end
                tab[a * (1 << OFF_TAB_W) + b] = DIST_W'(r);
            end
        end
        return tab;
    endfunction

    localparam dist_tab_t DIST_TAB = build_dist_tab();

endpackage

### hw/rtl/additive_radial_blob_splat.sv
// Additive radial blob splatter over an 8-bit frame store (top level).
// A splat scans every mirrored offset slot and drains the pipeline before its result shows;
// a read or write uses one slot. The next item is accepted in the cycle after the result loads.
// The rate is set by the frame store write port: one mirrored pixel slot per cycle.
// Reset runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells (16384) with in_ready low;
// configuration writes are taken during it. Depends on arbs_pkg, arbs_ctrl, arbs_dp.
module additive_radial_blob_splat #(
    parameter int unsigned MAX_RADIUS = arbs_pkg::DEF_MAX_RADIUS,
    parameter int unsigned MAX_WIDTH  = arbs_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = arbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [arbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arbs_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [arbs_pkg::REQ_W-1:0]         req_type,
    input  logic signed [arbs_pkg::POS_W-1:0]  pos_x,
    input  logic signed [arbs_pkg::POS_W-1:0]  pos_y,
    input  logic [arbs_pkg::LIFE_W-1:0]        life,
    input  logic [arbs_pkg::PIX_W-1:0]         write_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [arbs_pkg::PIX_W-1:0]         read_value,
    output logic [arbs_pkg::CNT_W-1:0]         pixels_touched
);

    import arbs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer
    arbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Pixel pipeline and frame store
    arbs_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .life           (life),
        .write_value    (write_value),
        .cmd            (cmd),
        .status         (status),
        .read_value     (read_value),
        .pixels_touched (pixels_touched)
    );

endmodule

### hw/rtl/arbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module arbs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/arbs_ctrl.sv
// Controller state machine of the blob splatter: clearing pass, scan, drain, result.
// Depends on arbs_pkg for the state enum and the command/status structs.
module arbs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  arbs_pkg::dp_status_t   status,
    output arbs_pkg::ctrl_cmd_t    cmd
);

    import arbs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Hold state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.slot_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/arbs_dp.sv
// Datapath of the blob splatter: config registers, offset scan, pixel pipeline,
// frame store and result registers. Depends on arbs_pkg and arbs_ram.
module arbs_dp #(
    parameter int unsigned MAX_RADIUS = arbs_pkg::DEF_MAX_RADIUS,
    parameter int unsigned MAX_WIDTH  = arbs_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = arbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [arbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arbs_pkg::CFG_W-1:0]         cfg_data,
    input  logic [arbs_pkg::REQ_W-1:0]         req_type,
    input  logic signed [arbs_pkg::POS_W-1:0]  pos_x,
    input  logic signed [arbs_pkg::POS_W-1:0]  pos_y,
    input  logic [arbs_pkg::LIFE_W-1:0]        life,
    input  logic [arbs_pkg::PIX_W-1:0]         write_value,
    input  arbs_pkg::ctrl_cmd_t                cmd,
    output arbs_pkg::dp_status_t               status,
    output logic [arbs_pkg::PIX_W-1:0]         read_value,
    output logic [arbs_pkg::CNT_W-1:0]         pixels_touched
);

    import arbs_pkg::*;

    localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned OFF_W   = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
    localparam int unsigned DIVISOR = 8 * MAX_RADIUS;
    // Rounded-up reciprocal: exact floor over every numerator that can occur
    localparam int unsigned RECIP   = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int unsigned RECIP_W = RECIP_SHIFT - 2;
    localparam int unsigned NUM_W   = RAD_W + 2;
    localparam int unsigned PROD_W  = NUM_W + RECIP_W;
    localparam int unsigned SPOS_W  = POS_W + 1;
    localparam int unsigned LIN_W   = 2 * CFG_W + 1;

    localparam logic [OFF_W-1:0]   OFF_LAST = OFF_W'(MAX_RADIUS - 1);
    localparam logic [AW-1:0]      CLR_LAST = AW'(DEPTH - 1);
    localparam logic [RECIP_W-1:0] RECIP_L  = RECIP_W'(RECIP);
    localparam logic [CFG_W-1:0]   WCAP     = CFG_W'((MAX_WIDTH > 255) ? 255 : MAX_WIDTH);
    localparam logic [CFG_W-1:0]   HCAP     = CFG_W'((MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT);

    // Configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;

    // Latched request
    logic [REQ_W-1:0]        req_reg;
    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] y_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [PIX_W-1:0]        wval_reg;
    logic [LIFE_W-1:0]       life_sat;
    logic                    is_splat;
    logic                    is_write;
    logic                    is_read;
    logic                    kind_ok;

    // Offset scan
    logic [OFF_W-1:0] tx_reg;
    logic [OFF_W-1:0] tx_next;
    logic [OFF_W-1:0] ty_reg;
    logic [OFF_W-1:0] ty_next;
    logic [MIR_W-1:0] mir_reg;
    logic [MIR_W-1:0] mir_next;
    logic             scan_last;

    // Slot evaluation
    logic [DIST_W-1:0]        dist_val;
    logic [RAD_W-1:0]         diff;
    logic [NUM_W-1:0]         num;
    logic                     in_rad;
    logic                     mir_ok;
    logic signed [SPOS_W-1:0] x_s;
    logic signed [SPOS_W-1:0] y_s;
    logic signed [SPOS_W-1:0] tx_s;
    logic signed [SPOS_W-1:0] ty_s;
    logic signed [SPOS_W-1:0] px;
    logic signed [SPOS_W-1:0] py;
    logic signed [SPOS_W-1:0] lo_s;
    logic signed [SPOS_W-1:0] w_s;
    logic signed [SPOS_W-1:0] h_s;
    logic                     in_frame;
    logic                     slot_ok;
    logic [2*CFG_W-1:0]       row_base;
    logic [LIN_W-1:0]         lin;

    // Pipeline stages
    logic              s1_occ_reg;
    logic              s1_ok_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [NUM_W-1:0]  s1_num_reg;
    logic [PROD_W-1:0] prod;
    logic              s2_occ_reg;
    logic              s2_ok_reg;
    logic [AW-1:0]     s2_addr_reg;
    logic [PIX_W-1:0]  s2_amt_reg;
    logic [PIX_W:0]    sum;
    logic [PIX_W-1:0]  sat;

    // Accumulators and result
    logic [CNT_W-1:0] touched_reg;
    logic [PIX_W-1:0] rd_acc_reg;
    logic [PIX_W-1:0] read_value_reg;
    logic [CNT_W-1:0] pixels_touched_reg;

    // Clearing pass and frame store ports
    logic [AW-1:0]    clr_cnt_reg;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PIX_W-1:0] ram_wdata;
    logic [PIX_W-1:0] ram_rdata;

    // Take configuration writes; other indexes do nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_W_RST;
            height_reg <= FRAME_H_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == CFG_FRAME_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // Clamp the active frame to the store size
    assign eff_w = (width_reg < WCAP) ? width_reg : WCAP;
    assign eff_h = (height_reg < HCAP) ? height_reg : HCAP;

    // Latch the request; the radius is R times life clamped to one
    assign life_sat = (life > LIFE_ONE) ? LIFE_ONE : life;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= REQ_W'(REQ_SPLAT);
        end
        else if (cmd.load)
        begin
            req_reg <= req_type;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= pos_x;
            y_reg    <= pos_y;
            rad_reg  <= RAD_W'(MAX_RADIUS * life_sat);
            wval_reg <= write_value;
        end
    end

    assign is_splat = (req_reg == REQ_SPLAT);
    assign is_read  = (req_reg == REQ_READ);
    assign is_write = (req_reg == REQ_WRITE);

    always_comb
    begin
        kind_ok = req_reg inside {REQ_SPLAT, REQ_READ, REQ_WRITE};
    end

    // Step through offsets; mirror bit 0 negates ty, bit 1 negates tx.
    // Reads and writes use one slot at offset zero.
    assign scan_last = !is_splat ||
                       ((tx_reg == OFF_LAST) && (ty_reg == OFF_LAST) && (mir_reg == MIR_LAST));

    always_comb
    begin
        tx_next  = tx_reg;
        ty_next  = ty_reg;
        mir_next = mir_reg;
        if (cmd.load)
        begin
            tx_next  = '0;
            ty_next  = '0;
            mir_next = '0;
        end
        else if (cmd.slot_step && !scan_last)
        begin
            mir_next = mir_reg + MIR_W'(1);
            if (mir_reg == MIR_LAST)
            begin
                if (ty_reg == OFF_LAST)
                begin
                    ty_next = '0;
                    tx_next = tx_reg + OFF_W'(1);
                end
                else
                begin
                    ty_next = ty_reg + OFF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg  <= '0;
            ty_reg  <= '0;
            mir_reg <= '0;
        end
        else
        begin
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            mir_reg <= mir_next;
        end
    end

    // Distance lookup and radius test
    assign dist_val = DIST_TAB[{OFF_TAB_W'(tx_reg), OFF_TAB_W'(ty_reg)}];
    assign in_rad   = (RAD_W'({tx_reg, FRAC_W'(0)}) < rad_reg) &&
                      (RAD_W'({ty_reg, FRAC_W'(0)}) < rad_reg) &&
                      (dist_val <= rad_reg);
    assign mir_ok   = (!mir_reg[0] || (ty_reg != '0)) && (!mir_reg[1] || (tx_reg != '0));
    assign diff     = rad_reg - dist_val;
    assign num      = (NUM_W'(diff) << 1) + NUM_W'(diff);

    // Pixel position and frame test; splats skip row and column zero
    assign x_s  = SPOS_W'(x_reg);
    assign y_s  = SPOS_W'(y_reg);
    assign tx_s = $signed(SPOS_W'(tx_reg));
    assign ty_s = $signed(SPOS_W'(ty_reg));
    assign px   = mir_reg[1] ? (x_s - tx_s) : (x_s + tx_s);
    assign py   = mir_reg[0] ? (y_s - ty_s) : (y_s + ty_s);
    assign lo_s = is_splat ? SPOS_W'(1) : SPOS_W'(0);
    assign w_s  = $signed(SPOS_W'(eff_w));
    assign h_s  = $signed(SPOS_W'(eff_h));

    assign in_frame = (px >= lo_s) && (py >= lo_s) && (px < w_s) && (py < h_s);
    assign slot_ok  = kind_ok && in_frame && (!is_splat || (in_rad && mir_ok));

    // Linear address y*width + x
    assign row_base = py[CFG_W-1:0] * eff_w;
    assign lin      = LIN_W'(row_base) + LIN_W'(px[CFG_W-1:0]);

    // Stage 1: address and numerator registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_occ_reg <= 1'b0;
            s1_ok_reg  <= 1'b0;
        end
        else
        begin
            s1_occ_reg <= cmd.slot_step;
            s1_ok_reg  <= cmd.slot_step && slot_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= AW'(lin);
        s1_num_reg  <= num;
    end

    // Stage 2: amount from the reciprocal product, store read in flight
    assign prod = PROD_W'(s1_num_reg) * PROD_W'(RECIP_L);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_occ_reg <= 1'b0;
            s2_ok_reg  <= 1'b0;
        end
        else
        begin
            s2_occ_reg <= s1_occ_reg;
            s2_ok_reg  <= s1_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_addr_reg <= s1_addr_reg;
        s2_amt_reg  <= prod[RECIP_SHIFT +: PIX_W];
    end

    // Saturating add on the returned pixel
    assign sum = {1'b0, ram_rdata} + {1'b0, s2_amt_reg};
    assign sat = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];

    // Drive the store write port: clearing pass, then splat and write updates
    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s2_ok_reg && (is_splat || is_write);
            ram_waddr = s2_addr_reg;
            ram_wdata = is_write ? wval_reg : sat;
        end
    end

    arbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (s1_addr_reg),
        .rdata (ram_rdata)
    );

    // Advance the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // Count splat updates and capture the read pixel
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            touched_reg <= '0;
            rd_acc_reg  <= '0;
        end
        else if (s2_ok_reg)
        begin
            if (is_splat && (touched_reg != CNT_MAX))
            begin
                touched_reg <= touched_reg + CNT_W'(1);
            end
            if (is_read)
            begin
                rd_acc_reg <= ram_rdata;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            read_value_reg     <= rd_acc_reg;
            pixels_touched_reg <= touched_reg;
        end
    end

    assign read_value       = read_value_reg;
    assign pixels_touched   = pixels_touched_reg;
    assign status.clear_last = (clr_cnt_reg == CLR_LAST);
    assign status.scan_last  = scan_last;
    assign status.pipe_busy  = s1_occ_reg || s2_occ_reg;

endmodule

### hw/rtl/arbs_checker.sv
// Port-level checker for the blob splatter, bound to the top level.
// Depends on arbs_pkg and additive_radial_blob_splat_assert.svh.
`include "additive_radial_blob_splat_assert.svh"

module arbs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [arbs_pkg::REQ_W-1:0]     req_type,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [arbs_pkg::PIX_W-1:0]     read_value,
    input logic [arbs_pkg::CNT_W-1:0]     pixels_touched
);

    import arbs_pkg::*;

    logic             busy_reg;
    logic [REQ_W-1:0] acc_req_reg;
    logic [REQ_W-1:0] show_req_reg;
    logic [REQ_W-1:0] shown_req;
    logic             prev_ov_reg;
    logic             prev_taken_reg;
    logic             new_result;

    // A fresh result shows when valid rises or reloads right after a transaction
    assign new_result = out_valid && (!prev_ov_reg || prev_taken_reg);
    assign shown_req  = new_result ? acc_req_reg : show_req_reg;

    // Track the item in flight and the request behind the shown result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            acc_req_reg    <= '0;
            show_req_reg   <= '0;
            prev_ov_reg    <= 1'b0;
            prev_taken_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                busy_reg    <= 1'b1;
                acc_req_reg <= req_type;
            end
            else if (new_result)
            begin
                busy_reg <= 1'b0;
            end
            show_req_reg   <= shown_req;
            prev_ov_reg    <= out_valid;
            prev_taken_reg <= out_valid && out_ready;
        end
    end

    `ARBS_ASSERT(a_one_in_flight, busy_reg && !new_result |-> !in_ready, "new transaction taken while an item is in flight")
    `ARBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(pixels_touched), "result dropped or changed while stalled")
    `ARBS_ASSERT(a_touched_splat_only, out_valid && (shown_req != REQ_SPLAT) |-> pixels_touched == '0, "pixel count nonzero for a request that is not a splat")
    `ARBS_ASSERT(a_read_only, out_valid && (shown_req != REQ_READ) |-> read_value == '0, "read value nonzero for a request that is not a read")

endmodule

bind additive_radial_blob_splat arbs_checker u_arbs_checker (.*);

### test/tb_additive_radial_blob_splat.sv
`timescale 1ns / 1ps
// Testbench for additive_radial_blob_splat: sends splat, read and write requests,
// predicts every result from a shadow frame store and checks it field by field.
// Depends on arbs_pkg and the RTL of the block.
module tb_additive_radial_blob_splat;
    import arbs_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int FRAME_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int RADIUS      = DEF_MAX_RADIUS;
    localparam int Q_ONE       = 256;
    localparam int PEAK_GAIN   = 96;
    localparam int POS_MIN     = -512;
    localparam int POS_SPAN    = 1023;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 120;
    localparam int IDLE_PCT    = 13;

    localparam logic [REQ_W-1:0]     REQ_NONE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic [CNT_W-1:0] touched;
        logic [REQ_W-1:0] kind;
        int               x;
        int               y;
    } outcome_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [LIFE_W-1:0]       life;
    logic [PIX_W-1:0]        write_value;
    logic                    out_valid;
    logic                    out_ready;
    logic [PIX_W-1:0]        read_value;
    logic [CNT_W-1:0]        pixels_touched;

    // Shadow of the block state
    logic [PIX_W-1:0] shadow_frame [FRAME_CELLS];
    int               shadow_w;
    int               shadow_h;

    outcome_t pending_results[$];
    logic     calm;
    int       fail_count;
    int       sent_count;
    int       checked_count;
    int       splat_count;
    int       cycle_count;
    int       last_cx;
    int       last_cy;

    additive_radial_blob_splat DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .life           (life),
        .write_value    (write_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_value     (read_value),
        .pixels_touched (pixels_touched)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int eff_w();
        return (shadow_w < DEF_MAX_WIDTH) ? shadow_w : DEF_MAX_WIDTH;
    endfunction

    function automatic int eff_h();
        return (shadow_h < DEF_MAX_HEIGHT) ? shadow_h : DEF_MAX_HEIGHT;
    endfunction

    // Distance in Q.8 for a squared offset, rounded to nearest
    function automatic int ring_dist(int n);
        int unsigned v;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        v  = n * 65536;
        lo = 0;
        hi = 2048;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        if (v - lo * lo > lo)
            lo++;
        return int'(lo);
    endfunction

    // Add to one pixel with saturation; return 1 when the pixel is in the frame and off row and column zero
    function automatic int brighten(int px, int py, int amt);
        int w;
        int h;
        int idx;
        int sum;
        w = eff_w();
        h = eff_h();
        if (px < 1 || py < 1 || px >= w || py >= h)
            return 0;
        idx = py * w + px;
        sum = int'(shadow_frame[idx]) + amt;
        shadow_frame[idx] = (sum > int'(PIX_MAX)) ? PIX_MAX : sum[PIX_W-1:0];
        return 1;
    endfunction

    // Apply one blob to the shadow frame and return the touched count
    function automatic int blob_touch(int cx, int cy, int lf);
        int rad;
        int d;
        int amt;
        int cnt;
        cnt = 0;
        rad = RADIUS * ((lf > int'(LIFE_ONE)) ? int'(LIFE_ONE) : lf);
        for (int tx = 0; tx * Q_ONE < rad; tx++) begin
            for (int ty = 0; ty * Q_ONE < rad; ty++) begin
                d = ring_dist(tx * tx + ty * ty);
                if (d <= rad) begin
                    amt = (PEAK_GAIN * (rad - d)) / (Q_ONE * RADIUS);
                    cnt += brighten(cx + tx, cy + ty, amt);
                    if (ty != 0)
                        cnt += brighten(cx + tx, cy - ty, amt);
                    if (tx != 0)
                        cnt += brighten(cx - tx, cy + ty, amt);
                    if (tx != 0 && ty != 0)
                        cnt += brighten(cx - tx, cy - ty, amt);
                end
            end
        end
        return (cnt > int'(CNT_MAX)) ? int'(CNT_MAX) : cnt;
    endfunction

    // Predict the result of one request and update the shadow state
    function automatic outcome_t forecast(logic [REQ_W-1:0] kind, int x, int y, int lf, int wv);
        outcome_t res;
        int       w;
        int       h;
        int       idx;
        bit       hit;
        res.pixel   = '0;
        res.touched = '0;
        res.kind    = kind;
        res.x       = x;
        res.y       = y;
        w   = eff_w();
        h   = eff_h();
        hit = (x >= 0 && y >= 0 && x < w && y < h);
        idx = y * w + x;
        case (kind)
            REQ_SPLAT: res.touched = CNT_W'(blob_touch(x, y, lf));
            REQ_READ:  if (hit) res.pixel = shadow_frame[idx];
            REQ_WRITE: if (hit) shadow_frame[idx] = PIX_W'(wv);
            default:   ;
        endcase
        return res;
    endfunction

    // Send one request; in_valid stays high after acceptance until the next gap or drain
    task automatic send_req(logic [REQ_W-1:0] kind, int x, int y, int lf, int wv);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        pos_x       <= POS_W'(x);
        pos_y       <= POS_W'(y);
        life        <= LIFE_W'(lf);
        write_value <= PIX_W'(wv);
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(forecast(kind, x, y, lf, wv));
        sent_count++;
        if (kind == REQ_SPLAT)
            splat_count++;
    endtask

    // Drop valid and wait until every expected transaction has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Write both frame registers and one unused index; the block must be idle
    task automatic program_frame(int w, int h, logic [CFG_IDX_W-1:0] spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        cfg_index <= spare;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we   <= 1'b0;
        shadow_w = w;
        shadow_h = h;
    endtask

    // One random request, mostly in and around the active frame
    task automatic random_req();
        int               w;
        int               h;
        int               roll;
        int               x;
        int               y;
        int               lf;
        int               wv;
        bit               near;
        logic [REQ_W-1:0] kind;
        w    = eff_w();
        h    = eff_h();
        near = 1'b0;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            kind = REQ_SPLAT;
        else if (roll < 75)
            kind = REQ_READ;
        else if (roll < 90)
            kind = REQ_WRITE;
        else
            kind = REQ_NONE;
        if ($urandom_range(0, 99) < 15) begin
            x = int'($urandom_range(0, POS_SPAN)) + POS_MIN;
            y = int'($urandom_range(0, POS_SPAN)) + POS_MIN;
        end else if (kind == REQ_READ && $urandom_range(0, 1) == 1) begin
            x = last_cx + int'($urandom_range(0, 10)) - 5;
            y = last_cy + int'($urandom_range(0, 10)) - 5;
        end else begin
            x    = int'($urandom_range(0, w + 11)) - 6;
            y    = int'($urandom_range(0, h + 11)) - 6;
            near = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
            lf = $urandom_range(0, 256);
        else if (roll < 85)
            lf = $urandom_range(180, 256);
        else
            lf = $urandom_range(257, 511);
        wv = ($urandom_range(0, 3) == 0) ? $urandom_range(240, 255) : $urandom_range(0, 255);
        if (kind == REQ_SPLAT && near) begin
            last_cx = x;
            last_cy = y;
        end
        send_req(kind, x, y, lf, wv);
    endtask

    task automatic run_random(int count);
        repeat (count) random_req();
        drain();
    endtask

    // Edges of every field, all request kinds, saturation, clipping at the frame border
    task automatic test_directed_basics();
        program_frame(FRAME_W_RST, FRAME_H_RST, CFG_SPARE_A);
        send_req(REQ_READ, 0, 0, 0, 0);
        send_req(REQ_WRITE, 127, 127, 0, 255);
        send_req(REQ_READ, 127, 127, 511, 0);
        send_req(REQ_WRITE, 128, 5, 0, 17);
        send_req(REQ_READ, -1, 5, 0, 0);
        send_req(REQ_WRITE, -512, 511, 0, 8'h5A);
        send_req(REQ_READ, 511, -512, 0, 0);
        send_req(REQ_NONE, 10, 10, 256, 255);
        send_req(REQ_SPLAT, 64, 64, 256, 0);
        send_req(REQ_READ, 64, 64, 0, 0);
        send_req(REQ_SPLAT, 64, 64, 256, 0);
        send_req(REQ_SPLAT, 64, 64, 511, 0);
        send_req(REQ_READ, 64, 64, 0, 0);
        send_req(REQ_READ, 68, 64, 0, 0);
        send_req(REQ_SPLAT, 40, 40, 0, 0);
        send_req(REQ_SPLAT, 40, 40, 1, 0);
        send_req(REQ_SPLAT, 0, 0, 256, 0);
        send_req(REQ_SPLAT, 127, 127, 257, 0);
        send_req(REQ_READ, 126, 126, 0, 0);
        send_req(REQ_SPLAT, -512, -512, 256, 0);
        send_req(REQ_SPLAT, 511, 511, 256, 0);
        send_req(REQ_SPLAT, 130, 60, 255, 0);
        send_req(REQ_WRITE, 10, 10, 0, 250);
        send_req(REQ_SPLAT, 10, 10, 128, 0);
        send_req(REQ_READ, 10, 10, 0, 0);
        drain();
    endtask

    // Widths and heights of zero and one, the smallest usable frame, oversized registers
    task automatic test_tiny_frames();
        program_frame(0, 0, CFG_SPARE_B);
        send_req(REQ_SPLAT, 1, 1, 256, 0);
        send_req(REQ_READ, 0, 0, 0, 0);
        drain();
        program_frame(1, 1, CFG_SPARE_A);
        send_req(REQ_WRITE, 0, 0, 0, 77);
        send_req(REQ_READ, 0, 0, 0, 0);
        send_req(REQ_SPLAT, 0, 0, 256, 0);
        drain();
        program_frame(2, 2, CFG_SPARE_B);
        send_req(REQ_SPLAT, 1, 1, 256, 0);
        send_req(REQ_READ, 1, 1, 0, 0);
        drain();
        program_frame(255, 255, CFG_SPARE_A);
        send_req(REQ_SPLAT, 124, 124, 256, 0);
        send_req(REQ_READ, 127, 127, 0, 0);
        drain();
    endtask

    // Random mix on a small frame so reads often land on splatted pixels
    task automatic test_random_small_frame();
        program_frame(16, 12, CFG_SPARE_B);
        run_random(110);
    endtask

    // No idling on either side for a long stretch
    task automatic test_back_to_back();
        calm <= 1'b1;
        program_frame(128, 128, CFG_SPARE_A);
        run_random(60);
        calm <= 1'b0;
    endtask

    // Wide and flat, narrow and tall, and a random size
    task automatic test_random_shapes();
        program_frame(255, 2, CFG_SPARE_B);
        run_random(40);
        program_frame(7, 200, CFG_SPARE_A);
        run_random(60);
        program_frame($urandom_range(2, 32), $urandom_range(2, 32), CFG_SPARE_B);
        run_random(110);
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge clk) begin : check_results
        outcome_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: read_value %0d pixels_touched %0d",
                         $time, read_value, pixels_touched);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (read_value !== want.pixel) begin
                    $display("%0t: read_value mismatch (req %0d at %0d,%0d): expected %0d, actual %0d",
                             $time, want.kind, want.x, want.y, want.pixel, read_value);
                    fail_count++;
                end
                if (pixels_touched !== want.touched) begin
                    $display("%0t: pixels_touched mismatch (req %0d at %0d,%0d): expected %0d, actual %0d",
                             $time, want.kind, want.x, want.y, want.touched, pixels_touched);
                    fail_count++;
                end
            end
        end
    end

    // Random back-pressure on the result side
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        req_type      = '0;
        pos_x         = '0;
        pos_y         = '0;
        life          = '0;
        write_value   = '0;
        out_ready     = 1'b0;
        calm          = 1'b0;
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        splat_count   = 0;
        cycle_count   = 0;
        last_cx       = 8;
        last_cy       = 8;
        shadow_w      = FRAME_W_RST;
        shadow_h      = FRAME_H_RST;
        foreach (shadow_frame[i])
            shadow_frame[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_basics();
        test_tiny_frames();
        test_random_small_frame();
        test_back_to_back();
        test_random_shapes();

        // Hold for any stray result
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            fail_count++;
        end

        $display("Covered %0d requests (%0d splats), %0d results checked, %0d failures;",
                 sent_count, splat_count, checked_count, fail_count);
        $display("frame sizes from 0 to 255, edge clipping, saturation and unknown codes exercised.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/arbs_pkg.sv
hw/rtl/arbs_ram.sv
hw/rtl/arbs_ctrl.sv
hw/rtl/arbs_dp.sv
hw/rtl/additive_radial_blob_splat.sv
hw/rtl/arbs_checker.sv
test/tb_additive_radial_blob_splat.sv
